@@ src/rsc_pkg.sv @@
// rsc_pkg: shared types and constants for the rpn stack calculator
// depends on nothing; imported by every module of the block
package rsc_pkg;

    localparam int DATA_W    = 32;
    localparam int MAX_SHOWN = 16;
    localparam int DIV_STEPS = 32;
    localparam int CMD_W     = 3;
    localparam int STATUS_W  = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SUB  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MUL  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DIV  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_MOD  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_POP  = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SHOW = 3'd7;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_UNDER = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DIVZ  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_OVER  = 2'd3;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_POP,
        CELL_LOAD
    } cell_op_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
        logic [DATA_W-1:0] remainder;
    } div_rsp_t;

endpackage

@@ src/rpn_stack_calculator.sv @@
// rpn_stack_calculator: postfix calculator over a chain of stack cells
// depends on rsc_pkg, rsc_cell and rsc_divider
//
//  channel | tvalid/tready | tdata          | tuser                       | tlast
//  s_      | token in      | [31:0] operand | [2:0] command               | -
//  m_      | result out    | [31:0] value   | [1:0] status, [2] has_value | last
//
// push, add, sub and pop complete in the idle step; mul passes through the mul and emit steps
// div and mod (unless the divisor is zero) wait in the div step for the 32-step divider, then emit
// show stack gives one result per cycle while the output is not stalled, up to sixteen, from the cell chain
// reset clears the state, the entry count and the result valid; the cells need no clearing
// a stalled result output holds the block in its idle, emit or show step
module rpn_stack_calculator #(
    parameter int STACK_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // operand
    input  logic [2:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // value
    output logic [2:0]  m_tuser,   // status, has_value
    output logic        m_tlast
);
    import rsc_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int IW = $clog2(STACK_DEPTH);
    localparam int SHOW_MAX = (STACK_DEPTH < MAX_SHOWN) ? STACK_DEPTH : MAX_SHOWN;
    localparam logic [CW-1:0] DEPTH_C    = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] SHOW_MAX_C = CW'(SHOW_MAX);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_EMIT = 3'd3;
    localparam logic [2:0] ST_SHOW = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       n_reg, n_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [DATA_W-1:0]   a_reg, a_next;
    logic [DATA_W-1:0]   b_reg, b_next;
    logic [DATA_W-1:0]   r_reg, r_next;
    logic                empty_reg, empty_next;

    logic                out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]   out_value_reg, out_value_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic                out_hv_reg, out_hv_next;
    logic                out_last_reg, out_last_next;

    logic [DATA_W-1:0]   cell_q    [STACK_DEPTH];
    logic [DATA_W-1:0]   cell_load [STACK_DEPTH];
    cell_op_t            cell_op   [STACK_DEPTH];

    div_req_t            div_req;
    div_rsp_t            div_rsp;

    logic                slot_free;
    logic [CMD_W-1:0]    cmd_in;
    logic [DATA_W-1:0]   top_val, sec_val, sum_val;
    logic [CW-1:0]       show_n;
    logic [2*DATA_W-1:0] prod;

    genvar g;
    generate
        for (g = 0; g < STACK_DEPTH; g++) begin : g_cell
            logic [DATA_W-1:0] above_d, below_d;
            if (g == 0) begin : g_top
                assign above_d = s_tdata;
            end else begin : g_mid
                assign above_d = cell_q[g-1];
            end
            if (g == STACK_DEPTH - 1) begin : g_bot
                assign below_d = '0;
            end else begin : g_up
                assign below_d = cell_q[g+1];
            end
            rsc_cell u_cell (
                .aclk      (aclk),
                .op        (cell_op[g]),
                .load_data (cell_load[g]),
                .above     (above_d),
                .below     (below_d),
                .q         (cell_q[g])
            );
        end
    endgenerate

    rsc_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign slot_free = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && slot_free;
    assign cmd_in    = s_tuser;
    assign top_val   = (count_reg >= CW'(1)) ? cell_q[0] : '0;
    assign sec_val   = (count_reg >= CW'(2)) ? cell_q[1] : '0;
    assign sum_val   = (cmd_in == CMD_ADD) ? (sec_val + top_val) : (sec_val - top_val);
    assign show_n    = (count_reg > SHOW_MAX_C) ? SHOW_MAX_C : count_reg;
    assign prod      = a_reg * b_reg;

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        n_next          = n_reg;
        idx_next        = idx_reg;
        cmd_next        = cmd_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        r_next          = r_reg;
        empty_next      = empty_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_hv_next     = out_hv_reg;
        out_last_next   = out_last_reg;
        div_req.start    = 1'b0;
        div_req.dividend = a_reg;
        div_req.divisor  = b_reg;
        for (int i = 0; i < STACK_DEPTH; i++) begin
            cell_op[i]   = CELL_HOLD;
            cell_load[i] = '0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && slot_free) begin
                    out_valid_next  = 1'b1;
                    out_value_next  = '0;
                    out_status_next = STATUS_OK;
                    out_hv_next     = 1'b0;
                    out_last_next   = 1'b1;
                    cmd_next        = cmd_in;
                    a_next          = sec_val;
                    b_next          = top_val;
                    empty_next      = (count_reg < CW'(2));
                    unique case (cmd_in)
                        CMD_PUSH: begin
                            if (count_reg < DEPTH_C) begin
                                for (int i = 0; i < STACK_DEPTH; i++) begin
                                    cell_op[i] = CELL_PUSH;
                                end
                                count_next = count_reg + CW'(1);
                            end else begin
                                out_status_next = STATUS_OVER;
                            end
                        end
                        CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD: begin
                            if ((cmd_in == CMD_DIV || cmd_in == CMD_MOD) && top_val == '0) begin
                                cell_op[0]      = CELL_LOAD;
                                cell_load[0]    = top_val;
                                cell_op[1]      = CELL_LOAD;
                                cell_load[1]    = sec_val;
                                count_next      = (count_reg < CW'(2)) ? CW'(2) : count_reg;
                                out_status_next = STATUS_DIVZ;
                            end else if (cmd_in == CMD_ADD || cmd_in == CMD_SUB) begin
                                for (int i = 0; i < STACK_DEPTH; i++) begin
                                    cell_op[i] = CELL_POP;
                                end
                                cell_op[0]      = CELL_LOAD;
                                cell_load[0]    = sum_val;
                                count_next      = (count_reg >= CW'(2)) ?
                                                  count_reg - CW'(1) : CW'(1);
                                out_value_next  = sum_val;
                                out_status_next = (count_reg < CW'(2)) ? STATUS_UNDER
                                                                       : STATUS_OK;
                            end else if (cmd_in == CMD_MUL) begin
                                out_valid_next = out_valid_reg && !m_tready;
                                state_next     = ST_MUL;
                            end else begin
                                out_valid_next   = out_valid_reg && !m_tready;
                                div_req.start    = 1'b1;
                                div_req.dividend = sec_val;
                                div_req.divisor  = top_val;
                                state_next       = ST_DIV;
                            end
                        end
                        CMD_POP: begin
                            if (count_reg == '0) begin
                                out_status_next = STATUS_UNDER;
                            end else begin
                                for (int i = 0; i < STACK_DEPTH; i++) begin
                                    cell_op[i] = CELL_POP;
                                end
                                count_next     = count_reg - CW'(1);
                                out_value_next = cell_q[0];
                                out_hv_next    = 1'b1;
                            end
                        end
                        CMD_SHOW: begin
                            if (count_reg != '0) begin
                                out_value_next = cell_q[0];
                                out_hv_next    = 1'b1;
                                out_last_next  = (show_n == CW'(1));
                                if (show_n != CW'(1)) begin
                                    n_next     = show_n;
                                    idx_next   = IW'(1);
                                    state_next = ST_SHOW;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_MUL: begin
                r_next     = prod[DATA_W-1:0];
                state_next = ST_EMIT;
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    r_next     = (cmd_reg == CMD_MOD) ? div_rsp.remainder : div_rsp.quotient;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    for (int i = 0; i < STACK_DEPTH; i++) begin
                        cell_op[i] = CELL_POP;
                    end
                    cell_op[0]      = CELL_LOAD;
                    cell_load[0]    = r_reg;
                    count_next      = (count_reg >= CW'(2)) ? count_reg - CW'(1) : CW'(1);
                    out_valid_next  = 1'b1;
                    out_value_next  = r_reg;
                    out_status_next = empty_reg ? STATUS_UNDER : STATUS_OK;
                    out_hv_next     = 1'b0;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_SHOW: begin
                if (slot_free) begin
                    out_valid_next  = 1'b1;
                    out_value_next  = cell_q[idx_reg];
                    out_status_next = STATUS_OK;
                    out_hv_next     = 1'b1;
                    out_last_next   = ((CW'(idx_reg) + CW'(1)) == n_reg);
                    idx_next        = idx_reg + IW'(1);
                    if ((CW'(idx_reg) + CW'(1)) == n_reg) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg          <= n_next;
        idx_reg        <= idx_next;
        cmd_reg        <= cmd_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        r_reg          <= r_next;
        empty_reg      <= empty_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_hv_reg     <= out_hv_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = {out_hv_reg, out_status_reg};
    assign m_tlast  = out_last_reg;

endmodule

@@ src/rsc_cell.sv @@
// rsc_cell: one stack entry of the cell chain
// depends on rsc_pkg
module rsc_cell (
    input  logic                        aclk,
    input  rsc_pkg::cell_op_t           op,
    input  logic [rsc_pkg::DATA_W-1:0]  load_data,
    input  logic [rsc_pkg::DATA_W-1:0]  above,
    input  logic [rsc_pkg::DATA_W-1:0]  below,
    output logic [rsc_pkg::DATA_W-1:0]  q
);
    import rsc_pkg::*;

    logic [DATA_W-1:0] q_reg, q_next;

    always_comb begin
        unique case (op)
            CELL_HOLD: q_next = q_reg;
            CELL_PUSH: q_next = above;
            CELL_POP:  q_next = below;
            CELL_LOAD: q_next = load_data;
            default:   q_next = q_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

@@ src/rsc_divider.sv @@
// rsc_divider: iterative signed divider, one quotient bit per cycle
// depends on rsc_pkg
module rsc_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  rsc_pkg::div_req_t req,
    output rsc_pkg::div_rsp_t rsp
);
    import rsc_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic              neg_q_reg, neg_q_next;
    logic              neg_r_reg, neg_r_next;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        trial      = {rem_reg, quo_reg[DATA_W-1]};
        diff       = trial - {1'b0, dvs_reg};
        if (req.start) begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            rem_next   = '0;
            quo_next   = req.dividend[DATA_W-1] ? -req.dividend : req.dividend;
            dvs_next   = req.divisor[DATA_W-1] ? -req.divisor : req.divisor;
            neg_q_next = req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
            neg_r_next = req.dividend[DATA_W-1];
        end else if (busy_reg) begin
            if (!diff[DATA_W]) begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = neg_q_reg ? -quo_reg : quo_reg;
    assign rsp.remainder = neg_r_reg ? -rem_reg : rem_reg;

endmodule

@@ src/rsc_checker.sv @@
// rsc_checker: port-level assertions for the rpn stack calculator
// depends on rsc_pkg; bound to rpn_stack_calculator
module rsc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);
    import rsc_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_shown_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> m_tuser[1:0] == STATUS_OK)
        else $error("shown value with error status");

    a_divz: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] == STATUS_DIVZ |-> m_tdata == '0 && m_tlast)
        else $error("bad divide by zero result");

    a_multi: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser[2])
        else $error("non-final result outside a stack dump");

endmodule

bind rpn_stack_calculator rsc_checker u_rsc_checker (.*);

@@ sim/tb_rpn_stack_calculator.sv @@
// tb_rpn_stack_calculator: self-checking testbench for the rpn stack calculator
// models the stack itself, drives random tokens with random gaps and back-pressure
// depends on rsc_pkg and rpn_stack_calculator
module tb_rpn_stack_calculator;
    timeunit 1ns;
    timeprecision 1ps;
    import rsc_pkg::*;

    localparam int DEPTH     = 16;
    localparam int WDOG_MAX  = 20000;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
        logic        has_value;
        logic        last;
    } result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    rpn_stack_calculator #(.STACK_DEPTH(DEPTH)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    logic [31:0] stack_mem [DEPTH];
    int          stack_depth = 0;
    result_t     expected_results [$];
    int          errors = 0;
    bit          hold_off = 1'b0;
    bit          no_gaps = 1'b0;
    int          idle_cycles = 0;

    function automatic logic [31:0] stack_pop(inout bit empty);
        if (stack_depth == 0) begin
            empty = 1'b1;
            return '0;
        end
        stack_depth--;
        return stack_mem[stack_depth];
    endfunction

    function automatic void stack_push(logic [31:0] v);
        if (stack_depth < DEPTH) begin
            stack_mem[stack_depth] = v;
            stack_depth++;
        end
    endfunction

    function automatic void predict_token(logic [2:0] cmd, logic [31:0] opnd);
        bit          empty;
        logic [31:0] a, b, r;
        int          n;
        empty = 1'b0;
        r = '0;
        if (cmd == CMD_PUSH) begin
            expected_results.push_back({32'd0,
                (stack_depth < DEPTH) ? STATUS_OK : STATUS_OVER, 1'b0, 1'b1});
            stack_push(opnd);
        end else if (cmd == CMD_POP) begin
            a = stack_pop(empty);
            expected_results.push_back(empty ? {32'd0, STATUS_UNDER, 1'b0, 1'b1}
                                             : {a, STATUS_OK, 1'b1, 1'b1});
        end else if (cmd == CMD_SHOW) begin
            n = (stack_depth > MAX_SHOWN) ? MAX_SHOWN : stack_depth;
            if (n == 0)
                expected_results.push_back({32'd0, STATUS_OK, 1'b0, 1'b1});
            for (int i = 0; i < n; i++)
                expected_results.push_back({stack_mem[stack_depth-1-i], STATUS_OK,
                                            1'b1, (i == n - 1)});
        end else begin
            b = stack_pop(empty);
            a = stack_pop(empty);
            if ((cmd == CMD_DIV || cmd == CMD_MOD) && b == 0) begin
                stack_push(a);
                stack_push(b);
                expected_results.push_back({32'd0, STATUS_DIVZ, 1'b0, 1'b1});
            end else begin
                case (cmd)
                    CMD_ADD: r = a + b;
                    CMD_SUB: r = a - b;
                    CMD_MUL: r = a * b;
                    CMD_DIV: r = (a == 32'h8000_0000 && b == '1) ? a
                                 : $unsigned($signed(a) / $signed(b));
                    default: r = (b == '1) ? 32'd0 : $unsigned($signed(a) % $signed(b));
                endcase
                stack_push(r);
                expected_results.push_back({r, empty ? STATUS_UNDER : STATUS_OK,
                                            1'b0, 1'b1});
            end
        end
    endfunction

    task automatic send_token(logic [2:0] cmd, logic [31:0] opnd);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= opnd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_token(cmd, opnd);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '1;
            3: return 32'd0;
            4: return $urandom_range(0, 9);
            default: return $urandom;
        endcase
    endfunction

    // receiver with random stalls and an occasional long hold-off
    initial begin
        int stall;
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                m_tready <= 1'b0;
            end else begin
                stall = no_gaps ? 0 : $urandom_range(0, 19);
                if (stall != 0 && $urandom_range(0, 3) == 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                    if (!hold_off) m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        result_t got, exp;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata, m_tuser[1:0], m_tuser[2], m_tlast};
            if (expected_results.size() == 0) begin
                $display("%0t: result with none expected, actual %h", $realtime, got);
                errors++;
            end else begin
                exp = expected_results.pop_front();
                if (got.value !== exp.value)
                    $display("%0t: value mismatch, expected %h actual %h",
                             $realtime, exp.value, got.value);
                if (got.status !== exp.status)
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $realtime, exp.status, got.status);
                if (got.has_value !== exp.has_value)
                    $display("%0t: has_value mismatch, expected %0d actual %0d",
                             $realtime, exp.has_value, got.has_value);
                if (got.last !== exp.last)
                    $display("%0t: last mismatch, expected %0d actual %0d",
                             $realtime, exp.last, got.last);
                if (got !== exp) errors++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic test_underflow();
        send_token(CMD_SHOW, 32'd0);
        send_token(CMD_POP, 32'd0);
        send_token(CMD_ADD, 32'd0);
        send_token(CMD_POP, 32'd0);
        send_token(CMD_SUB, 32'd5);
        send_token(CMD_POP, 32'd0);
    endtask

    task automatic test_arith_extremes();
        logic [31:0] vals [6] = '{32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff,
                                  32'd7, 32'hffff_fffd, 32'd0};
        send_token(CMD_PUSH, vals[0]);
        send_token(CMD_PUSH, vals[1]);
        send_token(CMD_DIV, 32'd0);
        send_token(CMD_PUSH, vals[1]);
        send_token(CMD_MOD, 32'd0);
        send_token(CMD_PUSH, vals[2]);
        send_token(CMD_PUSH, vals[2]);
        send_token(CMD_MUL, 32'd0);
        send_token(CMD_PUSH, vals[3]);
        send_token(CMD_PUSH, vals[4]);
        send_token(CMD_MOD, 32'd0);
        send_token(CMD_PUSH, vals[5]);
        send_token(CMD_DIV, 32'd0);
        send_token(CMD_SHOW, 32'd0);
        send_token(CMD_ADD, 32'hffff_ffff);
        send_token(CMD_POP, 32'd0);
        send_token(CMD_POP, 32'd0);
        send_token(CMD_MOD, 32'd0);
        send_token(CMD_SHOW, 32'd0);
        send_token(CMD_POP, 32'd0);
        send_token(CMD_POP, 32'd0);
    endtask

    task automatic test_overflow_under_hold_off();
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
            begin
                no_gaps = 1'b1;
                for (int i = 0; i < DEPTH + 2; i++) send_token(CMD_PUSH, $urandom);
                send_token(CMD_SHOW, 32'd0);
                no_gaps = 1'b0;
            end
        join
        wait_drained();
        for (int i = 0; i < DEPTH; i++) send_token(CMD_POP, 32'd0);
    endtask

    task automatic test_random_tokens();
        logic [2:0] cmd;
        for (int i = 0; i < 100; i++) begin
            if (stack_depth < 2 || $urandom_range(0, 2) == 0)
                cmd = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : CMD_PUSH;
            else
                cmd = 3'($urandom_range(1, 7));
            send_token(cmd, rand_operand());
            if (i % 50 == 49) wait_drained();
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_underflow();
        test_arith_extremes();
        test_overflow_under_hold_off();
        test_random_tokens();
        wait_drained();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
